[design/mtc_pkg.sv]
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and constants for the magnetometer trim block
// Register indexes, field widths, trim biases and the side-band record
// that rides along with the division pipeline.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // Register indexes on the configuration port
    localparam int NUM_REGS = 8;
    localparam logic [2:0] REG_XY_OFFSET = 3'd0;
    localparam logic [2:0] REG_XY_GAIN   = 3'd1;
    localparam logic [2:0] REG_XY_POLY   = 3'd2;
    localparam logic [2:0] REG_Z_SCALE1  = 3'd3;
    localparam logic [2:0] REG_Z_SCALE2  = 3'd4;
    localparam logic [2:0] REG_Z_SLOPE   = 3'd5;
    localparam logic [2:0] REG_Z_OFFSET  = 3'd6;
    localparam logic [2:0] REG_HALL_REF  = 3'd7;

    // Divider geometry: one quotient bit per stage
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 16;
    localparam int WORD_W = 16;
    localparam int LANES  = 2;
    localparam int LANE_T = 0;
    localparam int LANE_Z = 1;

    // Compensation constants
    localparam int T_BIAS    = 'h4000;
    localparam int G_BIAS    = 'h100000;
    localparam int GAIN_BIAS = 'hA0;
    localparam int Z_ROUND   = 1 << 15;

    typedef logic [NUM_W-1:0]  mtc_num_t;
    typedef logic [DEN_W-1:0]  mtc_den_t;
    typedef logic [WORD_W-1:0] mtc_word_t;

    // Per-item record carried beside the quotients
    typedef struct packed {
        logic              rdy;
        logic              fault;
        logic signed [12:0] xr;
        logic signed [12:0] yr;
        logic              zneg;
    } mtc_side_t;

endpackage

[design/mtc_div_pipe.sv]
// ----------------------------------------------------------------------------
// mtc_div_pipe: two-lane pipelined restoring divider
// Each stage retires one quotient bit for both lanes; the low quotient
// word and a side-band record come out of the last of the NUM_W stages.
// ----------------------------------------------------------------------------
module mtc_div_pipe (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  mtc_pkg::mtc_num_t [mtc_pkg::LANES-1:0] in_num,
    input  mtc_pkg::mtc_den_t [mtc_pkg::LANES-1:0] in_den,
    input  mtc_pkg::mtc_side_t                    in_side,
    output logic                                  out_valid,
    output mtc_pkg::mtc_word_t [mtc_pkg::LANES-1:0] out_quo,
    output mtc_pkg::mtc_side_t                    out_side
);
    import mtc_pkg::*;

    localparam int STAGES = NUM_W;

    logic [STAGES-1:0]      valid_reg;
    logic [STAGES-1:0]      valid_next;
    mtc_den_t [LANES-1:0]   rem_reg  [STAGES];
    mtc_den_t [LANES-1:0]   rem_next [STAGES];
    mtc_num_t [LANES-1:0]   quo_reg  [STAGES];
    mtc_num_t [LANES-1:0]   quo_next [STAGES];
    mtc_den_t [LANES-1:0]   den_reg  [STAGES];
    mtc_den_t [LANES-1:0]   den_next [STAGES];
    mtc_side_t              side_reg [STAGES];
    mtc_side_t              side_next[STAGES];

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input mtc_den_t rem,
        input mtc_num_t quo,
        input mtc_den_t den
    );
        logic [DEN_W:0] trial;
        logic           fits;
        logic [DEN_W:0] diff;
        trial = {rem, quo[NUM_W-1]};
        fits  = (trial >= {1'b0, den});
        diff  = trial - {1'b0, den};
        return {(fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0]),
                quo[NUM_W-2:0], fits};
    endfunction

    // Compute every stage's next contents from the stage before it
    always_comb
    begin
        valid_next[0] = in_valid;
        side_next[0]  = in_side;
        den_next[0]   = in_den;
        for (int l = 0; l < LANES; l++)
        begin
            {rem_next[0][l], quo_next[0][l]} = div_step('0, in_num[l], in_den[l]);
        end
        for (int s = 1; s < STAGES; s++)
        begin
            valid_next[s] = valid_reg[s-1];
            side_next[s]  = side_reg[s-1];
            den_next[s]   = den_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                {rem_next[s][l], quo_next[s][l]} =
                    div_step(rem_reg[s-1][l], quo_reg[s-1][l], den_reg[s-1][l]);
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                den_reg[s]  <= den_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    // Present the low quotient word of the last stage
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l] = quo_reg[STAGES-1][l][WORD_W-1:0];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

[design/magnetometer_trim_compensation.sv]
// ----------------------------------------------------------------------------
// magnetometer_trim_compensation: factory trim compensation for x, y, z
// Applies the temperature polynomial to x/y and the Hall-scaled division
// to z for each raw sensor read.
// ----------------------------------------------------------------------------
// Usage:
//   Load the eight trim registers over the APB port (register i at byte
//   address 4*i, low 16 bits of pwdata) while no beat is in flight.
//   Present one raw read (x, y, z, Hall words) per input beat with
//   in_valid/in_ready; each beat yields exactly one output beat carrying
//   sample_valid, the three compensated fields and divide_fault.
//   A new beat is taken every cycle while the pipeline is not held; the
//   depth is set by the 32-stage bit-per-stage divider that forms the
//   temperature term and the z quotient side by side, plus three stages
//   before it and six after it for the multiplies.
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset clears the trim registers and all valid bits.
// ----------------------------------------------------------------------------
module magnetometer_trim_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        x_raw_word,
    input  logic [15:0]        y_raw_word,
    input  logic [15:0]        z_raw_word,
    input  logic [15:0]        hall_raw_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               sample_valid,
    output logic signed [15:0] x_field,
    output logic signed [15:0] y_field,
    output logic signed [15:0] z_field,
    output logic               divide_fault
);
    import mtc_pkg::*;

    logic [15:0] cfg_reg [NUM_REGS];
    logic        adv;

    // Trim fields
    logic [15:0]        xyz1;
    logic [15:0]        z1;
    logic signed [15:0] z2_s;
    logic signed [15:0] z3_s;
    logic signed [15:0] z4_s;
    logic [7:0]         lin;
    logic signed [7:0]  quad_s;
    logic signed [7:0]  gain_x_s;
    logic signed [7:0]  gain_y_s;
    logic signed [7:0]  off_x_s;
    logic signed [7:0]  off_y_s;

    // Stage 1
    logic               v1_reg;
    logic               rdy1_reg, rdy1_next;
    logic signed [12:0] xr1_reg, xr1_next;
    logic signed [12:0] yr1_reg, yr1_next;
    logic signed [16:0] zp1_reg, zp1_next;
    logic [30:0]        m1_reg, m1_next;
    logic signed [32:0] m2_reg, m2_next;
    logic [15:0]        d1_reg, d1_next;

    // Stage 2
    logic               v2_reg;
    logic               rdy2_reg;
    logic signed [12:0] xr2_reg;
    logic signed [12:0] yr2_reg;
    logic signed [17:0] zdiv2_reg, zdiv2_next;
    logic signed [33:0] num2_reg, num2_next;
    logic [15:0]        d2_reg;
    logic               fault2_reg, fault2_next;

    // Stage 3
    logic               v3_reg;
    mtc_side_t          side3_reg, side3_next;
    mtc_num_t           nmag3_reg, nmag3_next;
    mtc_den_t           dmag3_reg, dmag3_next;
    mtc_den_t           dt3_reg;

    // Divider
    mtc_num_t [LANES-1:0]  div_num;
    mtc_den_t [LANES-1:0]  div_den;
    logic                  dv;
    mtc_word_t [LANES-1:0] dquo;
    mtc_side_t             dside;

    // Post stages
    logic               e1_v_reg, e2_v_reg, e3_v_reg, e4_v_reg, e5_v_reg;
    mtc_side_t          e1_side_reg, e2_side_reg, e3_side_reg, e4_side_reg, e5_side_reg;
    logic [15:0]        e1_z_reg, e1_z_next;
    logic [15:0]        e2_z_reg, e3_z_reg, e4_z_reg, e5_z_reg;
    logic signed [15:0] t_reg, t_next;
    logic [31:0]        sq_reg, sq_next;
    logic signed [24:0] tl_reg, tl_next;
    logic signed [33:0] a_reg, a_next;
    logic signed [35:0] gx_reg, gx_next;
    logic signed [35:0] gy_reg, gy_next;
    logic signed [36:0] px_reg, px_next;
    logic signed [36:0] py_reg, py_next;

    // Output register
    logic               out_valid_reg;
    logic               sv_reg, sv_next;
    logic [15:0]        xf_reg, xf_next;
    logic [15:0]        yf_reg, yf_next;
    logic [15:0]        zf_reg, zf_next;
    logic               fault_reg, fault_next;

    // Unpack the trim registers
    assign xyz1     = cfg_reg[REG_HALL_REF];
    assign z1       = cfg_reg[REG_Z_SCALE1];
    assign z2_s     = $signed(cfg_reg[REG_Z_SCALE2]);
    assign z3_s     = $signed(cfg_reg[REG_Z_SLOPE]);
    assign z4_s     = $signed(cfg_reg[REG_Z_OFFSET]);
    assign lin      = cfg_reg[REG_XY_POLY][7:0];
    assign quad_s   = $signed(cfg_reg[REG_XY_POLY][15:8]);
    assign gain_x_s = $signed(cfg_reg[REG_XY_GAIN][7:0]);
    assign gain_y_s = $signed(cfg_reg[REG_XY_GAIN][15:8]);
    assign off_x_s  = $signed(cfg_reg[REG_XY_OFFSET][7:0]);
    assign off_y_s  = $signed(cfg_reg[REG_XY_OFFSET][15:8]);

    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[paddr[4:2]] <= pwdata[15:0];
        end
    end

    assign prdata = {16'b0, cfg_reg[paddr[4:2]]};
    assign pready = 1'b1;

    // Hold the pipeline only when a result waits and the sink stalls
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Stage 1: unpack fields, z numerator terms, divisor pick
    always_comb
    begin
        logic signed [14:0] zr_s;
        logic [13:0]        r_u;
        logic signed [16:0] rdiff_s;
        zr_s      = $signed(z_raw_word[15:1]);
        r_u       = hall_raw_word[15:2];
        rdiff_s   = $signed({3'b0, r_u}) - 17'(signed'(xyz1));
        rdy1_next = hall_raw_word[0];
        xr1_next  = $signed(x_raw_word[15:3]);
        yr1_next  = $signed(y_raw_word[15:3]);
        zp1_next  = 17'(zr_s) - 17'(z4_s);
        m1_next   = {15'b0, z1} * {16'b0, r_u, 1'b0};
        m2_next   = 33'(z3_s) * 33'(rdiff_s);
        d1_next   = (r_u != '0) ? {2'b0, r_u} : xyz1;
    end

    // Stage 2: z divisor, z numerator, fault detect
    always_comb
    begin
        logic [14:0] rnd;
        rnd         = 15'((m1_reg + 31'(Z_ROUND)) >> 16);
        zdiv2_next  = 18'(z2_s) + $signed({3'b0, rnd});
        num2_next   = (34'(zp1_reg) <<< 15) - 34'(m2_reg >>> 2);
        fault2_next = (d1_reg == '0) || (zdiv2_next == '0);
    end

    // Stage 3: magnitudes for the unsigned divider
    always_comb
    begin
        logic signed [33:0] nneg;
        logic signed [17:0] dneg;
        nneg             = -num2_reg;
        dneg             = -zdiv2_reg;
        nmag3_next       = num2_reg[33] ? nneg[NUM_W-1:0] : num2_reg[NUM_W-1:0];
        dmag3_next       = zdiv2_reg[17] ? dneg[DEN_W-1:0] : zdiv2_reg[DEN_W-1:0];
        side3_next.rdy   = rdy2_reg;
        side3_next.fault = fault2_reg;
        side3_next.xr    = xr2_reg;
        side3_next.yr    = yr2_reg;
        side3_next.zneg  = num2_reg[33] ^ zdiv2_reg[17];
    end

    // Front stages valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Front stages payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdy1_reg   <= rdy1_next;
            xr1_reg    <= xr1_next;
            yr1_reg    <= yr1_next;
            zp1_reg    <= zp1_next;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            d1_reg     <= d1_next;
            rdy2_reg   <= rdy1_reg;
            xr2_reg    <= xr1_reg;
            yr2_reg    <= yr1_reg;
            zdiv2_reg  <= zdiv2_next;
            num2_reg   <= num2_next;
            d2_reg     <= d1_reg;
            fault2_reg <= fault2_next;
            side3_reg  <= side3_next;
            nmag3_reg  <= nmag3_next;
            dmag3_reg  <= dmag3_next;
            dt3_reg    <= d2_reg;
        end
    end

    // Temperature term lane and z quotient lane
    assign div_num[LANE_T] = {2'b0, xyz1, 14'b0};
    assign div_den[LANE_T] = dt3_reg;
    assign div_num[LANE_Z] = nmag3_reg;
    assign div_den[LANE_Z] = dmag3_reg;

    mtc_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (v3_reg),
        .in_num   (div_num),
        .in_den   (div_den),
        .in_side  (side3_reg),
        .out_valid(dv),
        .out_quo  (dquo),
        .out_side (dside)
    );

    // Post stages: temperature polynomial and x/y scaling
    always_comb
    begin
        logic signed [25:0] base;
        logic signed [9:0]  gxs;
        logic signed [9:0]  gys;
        logic signed [23:0] gxr;
        logic signed [23:0] gyr;
        t_next    = $signed(dquo[LANE_T] - 16'(T_BIAS));
        e1_z_next = dside.zneg ? 16'(-dquo[LANE_Z]) : dquo[LANE_Z];
        sq_next   = 32'(32'(t_reg) * 32'(t_reg));
        tl_next   = 25'(t_reg) * 25'($signed({1'b0, lin}));
        a_next    = 34'(quad_s) * 34'($signed({1'b0, sq_reg[31:7]}))
                  + (34'(tl_reg) <<< 7);
        base      = 26'(a_reg >>> 9) + 26'(G_BIAS);
        gxs       = 10'(gain_x_s) + 10'(GAIN_BIAS);
        gys       = 10'(gain_y_s) + 10'(GAIN_BIAS);
        gx_next   = 36'(base) * 36'(gxs);
        gy_next   = 36'(base) * 36'(gys);
        gxr       = 24'(gx_reg >>> 12);
        gyr       = 24'(gy_reg >>> 12);
        px_next   = 37'($signed(e4_side_reg.xr)) * 37'(gxr);
        py_next   = 37'($signed(e4_side_reg.yr)) * 37'(gyr);
    end

    // Output formatting: offsets, not-ready and fault zeroing
    always_comb
    begin
        logic [15:0] xo;
        logic [15:0] yo;
        xo = px_reg[28:13] + {{5{off_x_s[7]}}, off_x_s, 3'b0};
        yo = py_reg[28:13] + {{5{off_y_s[7]}}, off_y_s, 3'b0};
        sv_next    = e5_side_reg.rdy;
        fault_next = e5_side_reg.rdy && e5_side_reg.fault;
        if (e5_side_reg.rdy && !e5_side_reg.fault)
        begin
            xf_next = xo;
            yf_next = yo;
            zf_next = e5_z_reg;
        end
        else
        begin
            xf_next = '0;
            yf_next = '0;
            zf_next = '0;
        end
    end

    // Back stages valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg      <= 1'b0;
            e2_v_reg      <= 1'b0;
            e3_v_reg      <= 1'b0;
            e4_v_reg      <= 1'b0;
            e5_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e1_v_reg      <= dv;
            e2_v_reg      <= e1_v_reg;
            e3_v_reg      <= e2_v_reg;
            e4_v_reg      <= e3_v_reg;
            e5_v_reg      <= e4_v_reg;
            out_valid_reg <= e5_v_reg;
        end
    end

    // Back stages payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_side_reg <= dside;
            e1_z_reg    <= e1_z_next;
            t_reg       <= t_next;
            e2_side_reg <= e1_side_reg;
            e2_z_reg    <= e1_z_reg;
            sq_reg      <= sq_next;
            tl_reg      <= tl_next;
            e3_side_reg <= e2_side_reg;
            e3_z_reg    <= e2_z_reg;
            a_reg       <= a_next;
            e4_side_reg <= e3_side_reg;
            e4_z_reg    <= e3_z_reg;
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            e5_side_reg <= e4_side_reg;
            e5_z_reg    <= e4_z_reg;
            px_reg      <= px_next;
            py_reg      <= py_next;
            sv_reg      <= sv_next;
            xf_reg      <= xf_next;
            yf_reg      <= yf_next;
            zf_reg      <= zf_next;
            fault_reg   <= fault_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_valid = sv_reg;
    assign x_field      = $signed(xf_reg);
    assign y_field      = $signed(yf_reg);
    assign z_field      = $signed(zf_reg);
    assign divide_fault = fault_reg;

endmodule
